/* hw/rtl/decal_pool_with_aging_fade_assert.svh */
// Assertion macros shared by the decal pool RTL.
`ifndef DECAL_POOL_WITH_AGING_FADE_ASSERT_SVH
`define DECAL_POOL_WITH_AGING_FADE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decal pool check failed");

// Next-cycle implication, checked outside reset.
`define DP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decal pool check failed");

`endif

/* hw/rtl/dpool_pkg.sv */
// Package with sizes, codes and types of the decal pool.
`default_nettype none
package dpool_pkg;

  localparam int unsigned POOL_SIZE = 32;
  localparam int unsigned TIME_BITS = 16;

  localparam int unsigned SLOT_W = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int unsigned PROD_W = TIME_BITS + 8;
  localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_SPAWN  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_ALPHA = 2'd3;
  localparam logic [1:0] BYTE_RED   = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SPAWN  = 7'b0000010,
    ST_VISIT  = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  // Clamp a 16-bit input time to the stored time width.
  function automatic time_t sat_time(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > TIME_MAX) begin
      w = TIME_MAX;
    end
    return time_t'(w);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/decal_pool_with_aging_fade.sv */
// Decal slot pool: LIFO free chain, oldest-first eviction, ageing and fade.
//
// A spawn transfer takes a free slot or evicts the oldest and yields one acknowledge. A tick
// transfer walks the live slots oldest to newest: an expired slot is freed in its age check,
// and a reported slot outside its fade window takes the age check, then the hand-off of its
// report; a fading slot adds, per faded byte, one multiply plus an eight-step restoring divide
// in the single shared divider, for alpha alone or for red, green and blue. The tick closes
// with its last result. The block takes no new transfer while an item is in work; results
// wait in an output register under out_stall_i.
`default_nettype none
module decal_pool_with_aging_fade (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [15:0] life_ticks_i,
  input  wire logic [15:0] fade_ticks_i,
  input  wire logic        alpha_only_i,
  input  wire logic [31:0] color_in_i,
  input  wire logic [15:0] delta_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [4:0]       slot_o,
  output logic             evicted_o,
  output logic [31:0]      color_now_o,
  output logic             last_o
);

  localparam int unsigned PS = dpool_pkg::POOL_SIZE;

  dpool_pkg::state_e state_q, state_d;

  // Linked list, free chain and per-slot data
  logic [PS-1:0]           live_q, live_d;
  dpool_pkg::slot_t        newer_q [PS];
  dpool_pkg::slot_t        newer_d [PS];
  dpool_pkg::slot_t        older_q [PS];
  dpool_pkg::slot_t        older_d [PS];
  dpool_pkg::cnt_t         fnext_q [PS];
  dpool_pkg::cnt_t         fnext_d [PS];
  dpool_pkg::time_t        age_q [PS];
  dpool_pkg::time_t        age_d [PS];
  dpool_pkg::time_t        life_q [PS];
  dpool_pkg::time_t        life_d [PS];
  dpool_pkg::time_t        fstart_q [PS];
  dpool_pkg::time_t        fstart_d [PS];
  dpool_pkg::time_t        flen_q [PS];
  dpool_pkg::time_t        flen_d [PS];
  logic [PS-1:0]           aonly_q, aonly_d;
  logic [31:0]             base_q [PS];
  logic [31:0]             base_d [PS];
  logic [31:0]             cnow_q [PS];
  logic [31:0]             cnow_d [PS];

  dpool_pkg::cnt_t         fhead_q, fhead_d;
  dpool_pkg::slot_t        newest_q, newest_d;
  dpool_pkg::slot_t        oldest_q, oldest_d;
  dpool_pkg::cnt_t         live_count_q, live_count_d;

  // Item and walk registers
  logic [15:0]             life_in_q, life_in_d;
  logic [15:0]             fade_in_q, fade_in_d;
  logic                    aonly_in_q, aonly_in_d;
  logic [31:0]             color_in_q, color_in_d;
  logic [15:0]             delta_q, delta_d;
  dpool_pkg::slot_t        idx_q, idx_d;
  dpool_pkg::slot_t        nxt_q, nxt_d;
  dpool_pkg::cnt_t         walk_q, walk_d;
  dpool_pkg::time_t        rem_q, rem_d;
  dpool_pkg::time_t        len_q, len_d;
  logic [1:0]              byte_q, byte_d;
  logic [dpool_pkg::PROD_W-1:0] prod_q, prod_d;
  dpool_pkg::time_t        divr_q, divr_d;
  logic [6:0]              quo_q, quo_d;
  logic [2:0]              bit_q, bit_d;
  logic                    held_q, held_d;
  dpool_pkg::slot_t        held_slot_q, held_slot_d;
  logic [31:0]             held_color_q, held_color_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              kind_q, kind_d;
  dpool_pkg::slot_t        slot_q, slot_d;
  logic                    ev_q, ev_d;
  logic [31:0]             color_q, color_d;
  logic                    last_q, last_d;

  logic                    out_free;
  logic                    accept;

  // Datapath temporaries
  logic [32:0]             age_sum;
  dpool_pkg::time_t        age_new;
  dpool_pkg::time_t        life_s, fade_s;
  logic                    evict;
  dpool_pkg::slot_t        spawn_slot;
  dpool_pkg::time_t        r_cur;
  logic [dpool_pkg::TIME_BITS:0] r_shift;
  logic                    q_bit;
  logic [7:0]              q_byte;
  logic [7:0]              base_byte;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != dpool_pkg::ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;

  // Shared datapath pieces
  always_comb begin
    age_sum   = 33'(age_q[idx_q]) + 33'(delta_q);
    age_new   = (age_sum > 33'(dpool_pkg::TIME_MAX)) ? dpool_pkg::time_t'(dpool_pkg::TIME_MAX)
                                                      : dpool_pkg::time_t'(age_sum);
    life_s    = dpool_pkg::sat_time(life_in_q);
    fade_s    = dpool_pkg::sat_time(fade_in_q);
    evict     = (fhead_q >= dpool_pkg::cnt_t'(PS));
    spawn_slot = evict ? oldest_q : fhead_q[dpool_pkg::SLOT_W-1:0];
    r_cur     = (bit_q == 3'd0) ? prod_q[dpool_pkg::PROD_W-1:8] : divr_q;
    r_shift   = {r_cur, prod_q[3'd7 - bit_q]};
    q_bit     = (r_shift >= {1'b0, len_q});
    q_byte    = {quo_q, q_bit};
    base_byte = base_q[idx_q][8*byte_q +: 8];
  end

  // Sequencer and next state
  always_comb begin
    state_d = state_q;
    live_d = live_q;
    newer_d = newer_q;
    older_d = older_q;
    fnext_d = fnext_q;
    age_d = age_q;
    life_d = life_q;
    fstart_d = fstart_q;
    flen_d = flen_q;
    aonly_d = aonly_q;
    base_d = base_q;
    cnow_d = cnow_q;
    fhead_d = fhead_q;
    newest_d = newest_q;
    oldest_d = oldest_q;
    live_count_d = live_count_q;
    life_in_d = life_in_q;
    fade_in_d = fade_in_q;
    aonly_in_d = aonly_in_q;
    color_in_d = color_in_q;
    delta_d = delta_q;
    idx_d = idx_q;
    nxt_d = nxt_q;
    walk_d = walk_q;
    rem_d = rem_q;
    len_d = len_q;
    byte_d = byte_q;
    prod_d = prod_q;
    divr_d = divr_q;
    quo_d = quo_q;
    bit_d = bit_q;
    held_d = held_q;
    held_slot_d = held_slot_q;
    held_color_d = held_color_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d = kind_q;
    slot_d = slot_q;
    ev_d = ev_q;
    color_d = color_q;
    last_d = last_q;

    unique case (state_q)
      dpool_pkg::ST_IDLE: begin
        // Latch the transfer and pick the operation
        if (accept) begin
          life_in_d = life_ticks_i;
          fade_in_d = fade_ticks_i;
          aonly_in_d = alpha_only_i;
          color_in_d = color_in_i;
          delta_d = delta_ticks_i;
          if (op_i == dpool_pkg::OP_SPAWN) begin
            state_d = dpool_pkg::ST_SPAWN;
          end else begin
            walk_d = live_count_q;
            idx_d = oldest_q;
            held_d = 1'b0;
            state_d = (live_count_q == '0) ? dpool_pkg::ST_FINISH : dpool_pkg::ST_VISIT;
          end
        end
      end

      dpool_pkg::ST_SPAWN: begin
        // Take a slot, link it as newest and acknowledge
        if (out_free) begin
          if (evict) begin
            oldest_d = newer_q[oldest_q];
            newer_d[newest_q] = spawn_slot;
            older_d[spawn_slot] = newest_q;
          end else begin
            fhead_d = fnext_q[spawn_slot];
            if (live_count_q == '0) begin
              oldest_d = spawn_slot;
            end else begin
              newer_d[newest_q] = spawn_slot;
              older_d[spawn_slot] = newest_q;
            end
            live_count_d = live_count_q + dpool_pkg::cnt_t'(1);
          end
          newest_d = spawn_slot;
          live_d[spawn_slot] = 1'b1;
          age_d[spawn_slot] = '0;
          life_d[spawn_slot] = life_s;
          flen_d[spawn_slot] = (fade_s > life_s) ? life_s : fade_s;
          fstart_d[spawn_slot] = (fade_s > life_s) ? '0 : life_s - fade_s;
          aonly_d[spawn_slot] = aonly_in_q;
          base_d[spawn_slot] = color_in_q;
          cnow_d[spawn_slot] = color_in_q;
          out_valid_d = 1'b1;
          kind_d = dpool_pkg::KIND_SPAWN;
          slot_d = spawn_slot;
          ev_d = evict;
          color_d = color_in_q;
          last_d = 1'b1;
          state_d = dpool_pkg::ST_IDLE;
        end
      end

      dpool_pkg::ST_VISIT: begin
        // Age the slot, then free it, fade it or report it
        age_d[idx_q] = age_new;
        nxt_d = newer_q[idx_q];
        if (life_q[idx_q] <= age_new) begin
          if (live_count_q <= dpool_pkg::cnt_t'(1)) begin
            live_count_d = '0;
          end else begin
            if (idx_q == oldest_q) begin
              oldest_d = newer_q[idx_q];
            end else if (idx_q == newest_q) begin
              newest_d = older_q[idx_q];
            end else begin
              newer_d[older_q[idx_q]] = newer_q[idx_q];
              older_d[newer_q[idx_q]] = older_q[idx_q];
            end
            live_count_d = live_count_q - dpool_pkg::cnt_t'(1);
          end
          live_d[idx_q] = 1'b0;
          fnext_d[idx_q] = fhead_q;
          fhead_d = dpool_pkg::cnt_t'(idx_q);
          walk_d = walk_q - dpool_pkg::cnt_t'(1);
          idx_d = newer_q[idx_q];
          state_d = (walk_q == dpool_pkg::cnt_t'(1)) ? dpool_pkg::ST_FINISH
                                                     : dpool_pkg::ST_VISIT;
        end else if (flen_q[idx_q] != '0 && fstart_q[idx_q] < age_new) begin
          rem_d = life_q[idx_q] - age_new;
          len_d = flen_q[idx_q];
          byte_d = aonly_q[idx_q] ? dpool_pkg::BYTE_ALPHA : dpool_pkg::BYTE_RED;
          state_d = dpool_pkg::ST_MUL;
        end else begin
          state_d = dpool_pkg::ST_EMIT;
        end
      end

      dpool_pkg::ST_MUL: begin
        // Form base byte times remaining time
        prod_d = dpool_pkg::PROD_W'(base_byte) * dpool_pkg::PROD_W'(rem_q);
        bit_d = 3'd0;
        state_d = dpool_pkg::ST_DIV;
      end

      dpool_pkg::ST_DIV: begin
        // One restoring divide step per cycle
        divr_d = q_bit ? dpool_pkg::time_t'(r_shift - {1'b0, len_q})
                       : dpool_pkg::time_t'(r_shift);
        quo_d = q_byte[6:0];
        bit_d = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          cnow_d[idx_q][8*byte_q +: 8] = q_byte;
          if (byte_q == dpool_pkg::BYTE_ALPHA || byte_q == dpool_pkg::BYTE_BLUE) begin
            state_d = dpool_pkg::ST_EMIT;
          end else begin
            byte_d = byte_q - 2'd1;
            state_d = dpool_pkg::ST_MUL;
          end
        end
      end

      dpool_pkg::ST_EMIT: begin
        // Push the previous report out and hold this one
        if (!held_q || out_free) begin
          if (held_q) begin
            out_valid_d = 1'b1;
            kind_d = dpool_pkg::KIND_REPORT;
            slot_d = held_slot_q;
            ev_d = 1'b0;
            color_d = held_color_q;
            last_d = 1'b0;
          end
          held_d = 1'b1;
          held_slot_d = idx_q;
          held_color_d = cnow_q[idx_q];
          walk_d = walk_q - dpool_pkg::cnt_t'(1);
          idx_d = nxt_q;
          state_d = (walk_q == dpool_pkg::cnt_t'(1)) ? dpool_pkg::ST_FINISH
                                                     : dpool_pkg::ST_VISIT;
        end
      end

      dpool_pkg::ST_FINISH: begin
        // Close the tick with the held report or an empty marker
        if (out_free) begin
          out_valid_d = 1'b1;
          ev_d = 1'b0;
          last_d = 1'b1;
          if (held_q) begin
            kind_d = dpool_pkg::KIND_REPORT;
            slot_d = held_slot_q;
            color_d = held_color_q;
          end else begin
            kind_d = dpool_pkg::KIND_NONE;
            slot_d = '0;
            color_d = '0;
          end
          held_d = 1'b0;
          state_d = dpool_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dpool_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpool_pkg::ST_IDLE;
      live_q <= '0;
      for (int i = 0; i < PS; i++) begin
        fnext_q[i] <= dpool_pkg::cnt_t'(i + 1);
      end
      fhead_q <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      live_count_q <= '0;
      held_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q <= live_d;
      fnext_q <= fnext_d;
      fhead_q <= fhead_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      live_count_q <= live_count_d;
      held_q <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    newer_q <= newer_d;
    older_q <= older_d;
    age_q <= age_d;
    life_q <= life_d;
    fstart_q <= fstart_d;
    flen_q <= flen_d;
    aonly_q <= aonly_d;
    base_q <= base_d;
    cnow_q <= cnow_d;
    life_in_q <= life_in_d;
    fade_in_q <= fade_in_d;
    aonly_in_q <= aonly_in_d;
    color_in_q <= color_in_d;
    delta_q <= delta_d;
    idx_q <= idx_d;
    nxt_q <= nxt_d;
    walk_q <= walk_d;
    rem_q <= rem_d;
    len_q <= len_d;
    byte_q <= byte_d;
    prod_q <= prod_d;
    divr_q <= divr_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
    held_slot_q <= held_slot_d;
    held_color_q <= held_color_d;
    kind_q <= kind_d;
    slot_q <= slot_d;
    ev_q <= ev_d;
    color_q <= color_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = 5'(slot_q);
  assign evicted_o   = ev_q;
  assign color_now_o = color_q;
  assign last_o      = last_q;

`include "decal_pool_with_aging_fade_assert.svh"

  `DP_ASSERT_IMPL(a_count_bound, 1'b1, live_count_q <= dpool_pkg::cnt_t'(PS))
  `DP_ASSERT_IMPL(a_chain_empty_full, fhead_q >= dpool_pkg::cnt_t'(PS), live_count_q == dpool_pkg::cnt_t'(PS))
  `DP_ASSERT_IMPL(a_oldest_live, live_count_q != '0, live_q[oldest_q])
  `DP_ASSERT_NEXT(a_empty_tick, state_q == dpool_pkg::ST_FINISH && !held_q && out_free, out_valid_o && kind_o == dpool_pkg::KIND_NONE && last_o)

endmodule
`default_nettype wire

/* tb/sv/tb_decal_pool_with_aging_fade.sv */
// Self-checking testbench for the decal pool with ageing and fade.
`timescale 1ns / 1ps
module tb_decal_pool_with_aging_fade;

  typedef struct packed {
    logic        op;
    logic [15:0] life;
    logic [15:0] fade;
    logic        alpha_only;
    logic [31:0] color;
    logic [15:0] delta;
  } decal_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic        evicted;
    logic [31:0] color_now;
    logic        last;
  } decal_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [15:0] life_ticks_i = '0;
  logic [15:0] fade_ticks_i = '0;
  logic        alpha_only_i = 1'b0;
  logic [31:0] color_in_i = '0;
  logic [15:0] delta_ticks_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [4:0]  slot_o;
  logic        evicted_o;
  logic [31:0] color_now_o;
  logic        last_o;

  decal_pool_with_aging_fade DUT (.*);

  // Predicted pool state.
  logic        pool_live [dpool_pkg::POOL_SIZE];
  logic [4:0]  link_newer [dpool_pkg::POOL_SIZE];
  logic [4:0]  link_older [dpool_pkg::POOL_SIZE];
  logic [5:0]  chain_next [dpool_pkg::POOL_SIZE];
  logic [5:0]  chain_head;
  logic [4:0]  newest, oldest;
  int unsigned nlive;
  logic [15:0] age_q [dpool_pkg::POOL_SIZE];
  logic [15:0] life_q [dpool_pkg::POOL_SIZE];
  logic [15:0] fstart_q [dpool_pkg::POOL_SIZE];
  logic [15:0] flen_q [dpool_pkg::POOL_SIZE];
  logic        aonly_q [dpool_pkg::POOL_SIZE];
  logic [31:0] base_q [dpool_pkg::POOL_SIZE];
  logic [31:0] now_q [dpool_pkg::POOL_SIZE];

  decal_item_t   pending_items [$];
  decal_result_t expected_results [$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_send = 1'b0;
  bit            in_fire = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void pool_clear();
    for (int i = 0; i < dpool_pkg::POOL_SIZE; i++) begin
      pool_live[i] = 1'b0;
      chain_next[i] = 6'(i + 1);
    end
    chain_head = '0;
    newest = '0;
    oldest = '0;
    nlive = 0;
  endfunction

  function automatic void unlink_slot(logic [4:0] s);
    if (nlive <= 1) begin
      nlive = 0;
    end else begin
      if (s == oldest) oldest = link_newer[s];
      else if (s == newest) newest = link_older[s];
      else begin
        link_newer[link_older[s]] = link_newer[s];
        link_older[link_newer[s]] = link_older[s];
      end
      nlive--;
    end
    pool_live[s] = 1'b0;
  endfunction

  function automatic logic [7:0] fade_byte(logic [7:0] b, logic [15:0] rem, logic [15:0] len);
    return 8'((24'(b) * 24'(rem)) / 24'(len));
  endfunction

  // Work out the results of one accepted item.
  function automatic void predict_decal(decal_item_t it);
    decal_result_t r;
    logic [4:0]    s, cur, nxt;
    logic [16:0]   sum;
    logic [15:0]   fd, a, rem;
    logic [31:0]   c;
    int            n, k;
    if (it.op == dpool_pkg::OP_SPAWN) begin
      r = '0;
      if (chain_head < dpool_pkg::POOL_SIZE) begin
        s = chain_head[4:0];
        chain_head = chain_next[s];
      end else begin
        s = oldest;
        unlink_slot(s);
        r.evicted = 1'b1;
      end
      if (nlive == 0) oldest = s;
      else begin
        link_newer[newest] = s;
        link_older[s] = newest;
      end
      newest = s;
      nlive++;
      pool_live[s] = 1'b1;
      fd = (it.fade > it.life) ? it.life : it.fade;
      age_q[s] = '0;
      life_q[s] = it.life;
      flen_q[s] = fd;
      fstart_q[s] = it.life - fd;
      aonly_q[s] = it.alpha_only;
      base_q[s] = it.color;
      now_q[s] = it.color;
      r.kind = dpool_pkg::KIND_SPAWN;
      r.slot = s;
      r.color_now = it.color;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      n = nlive;
      cur = oldest;
      k = 0;
      for (int i = 0; i < n; i++) begin
        nxt = link_newer[cur];
        sum = 17'(age_q[cur]) + 17'(it.delta);
        a = sum[16] ? 16'hFFFF : sum[15:0];
        age_q[cur] = a;
        if (life_q[cur] <= a) begin
          unlink_slot(cur);
          chain_next[cur] = chain_head;
          chain_head = 6'(cur);
        end else begin
          if (flen_q[cur] != 0 && fstart_q[cur] < a) begin
            rem = life_q[cur] - a;
            c = base_q[cur];
            if (aonly_q[cur])
              now_q[cur][31:24] = fade_byte(c[31:24], rem, flen_q[cur]);
            else begin
              now_q[cur][23:16] = fade_byte(c[23:16], rem, flen_q[cur]);
              now_q[cur][15:8] = fade_byte(c[15:8], rem, flen_q[cur]);
              now_q[cur][7:0] = fade_byte(c[7:0], rem, flen_q[cur]);
            end
          end
          r = '0;
          r.kind = dpool_pkg::KIND_REPORT;
          r.slot = cur;
          r.color_now = now_q[cur];
          expected_results.push_back(r);
          k++;
        end
        cur = nxt;
      end
      if (k == 0) begin
        r = '0;
        r.kind = dpool_pkg::KIND_NONE;
        r.last = 1'b1;
        expected_results.push_back(r);
      end else begin
        expected_results[$].last = 1'b1;
      end
    end
  endfunction

  function automatic decal_item_t spawn_item(logic [15:0] l, logic [15:0] f, logic ao,
                                            logic [31:0] c);
    decal_item_t it;
    it = '0;
    it.op = dpool_pkg::OP_SPAWN;
    it.life = l;
    it.fade = f;
    it.alpha_only = ao;
    it.color = c;
    it.delta = 16'($urandom);
    return it;
  endfunction

  function automatic decal_item_t tick_item(logic [15:0] d);
    decal_item_t it;
    it = '0;
    it.op = dpool_pkg::OP_TICK;
    it.life = 16'($urandom);
    it.fade = 16'($urandom);
    it.alpha_only = 1'($urandom);
    it.color = $urandom;
    it.delta = d;
    return it;
  endfunction

  function automatic decal_item_t random_item();
    logic [15:0] l;
    if ($urandom_range(0, 99) < 62) begin
      case ($urandom_range(0, 3))
        0: l = 16'($urandom);
        1: l = 16'hFFFF;
        default: l = 16'($urandom_range(1, 300));
      endcase
      return spawn_item(l, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                        : 16'($urandom_range(0, 320)), 1'($urandom), $urandom);
    end
    case ($urandom_range(0, 5))
      0: return tick_item(16'($urandom));
      1: return tick_item('0);
      default: return tick_item(16'($urandom_range(1, 60)));
    endcase
  endfunction

  // Driver: present queued items at the falling edge, hold until transferred.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_items.size() != 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          {op_i, life_ticks_i, fade_ticks_i, alpha_only_i, color_in_i, delta_ticks_i}
            <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predict on input transfers, compare on output transfers.
  always @(posedge clk_i) begin
    decal_result_t exp_r;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        predict_decal({op_i, life_ticks_i, fade_ticks_i, alpha_only_i, color_in_i,
                       delta_ticks_i});
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind %0d slot %0d", kind_o, slot_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (kind_o !== exp_r.kind) begin
            $error("kind expected %0h actual %0h", exp_r.kind, kind_o);
            errors++;
          end
          if (slot_o !== exp_r.slot) begin
            $error("slot expected %0h actual %0h", exp_r.slot, slot_o);
            errors++;
          end
          if (evicted_o !== exp_r.evicted) begin
            $error("evicted expected %0h actual %0h", exp_r.evicted, evicted_o);
            errors++;
          end
          if (color_now_o !== exp_r.color_now) begin
            $error("color_now expected %0h actual %0h", exp_r.color_now, color_now_o);
            errors++;
          end
          if (last_o !== exp_r.last) begin
            $error("last expected %0h actual %0h", exp_r.last, last_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic drain_items();
    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    pool_clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty tick, extremes, fade modes, saturation, eviction.
    pending_items.push_back(tick_item(16'hFFFF));
    pending_items.push_back(spawn_item(16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    pending_items.push_back(spawn_item(16'd0, 16'd0, 1'b0, 32'h0000_0000));
    pending_items.push_back(spawn_item(16'd100, 16'd40, 1'b0, 32'h80FF_7F01));
    pending_items.push_back(spawn_item(16'd100, 16'd200, 1'b1, 32'hFF12_3456));
    pending_items.push_back(spawn_item(16'd50, 16'd0, 1'b1, 32'hAA55_AA55));
    pending_items.push_back(tick_item(16'd0));
    pending_items.push_back(tick_item(16'd61));
    pending_items.push_back(tick_item(16'd30));
    pending_items.push_back(tick_item(16'hFFFF));
    pending_items.push_back(tick_item(16'hFFFF));
    pending_items.push_back(tick_item(16'd1));
    for (int i = 0; i < 34; i++)
      pending_items.push_back(spawn_item(16'($urandom_range(1000, 65535)),
                              16'($urandom), 1'($urandom), $urandom));
    pending_items.push_back(tick_item(16'd900));
    drain_items();

    // Hold off until the block has returned every expected result.
    hold_send = 1'b1;
    while (expected_results.size() != 0) @(posedge clk_i);
    hold_send = 1'b0;

    // Random traffic through the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 35 : 70) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 35 : 70) : 0;
      for (int i = 0; i < 105; i++) pending_items.push_back(random_item());
      drain_items();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0)
      $display("decal_pool_with_aging_fade verification clean");
    else
      $display("decal_pool_with_aging_fade verification failed");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #50ms;
    $display("decal_pool_with_aging_fade verification failed");
    $finish;
  end
endmodule
